### rtl/core/frame_protocol_classifier_assert.svh
// ----------------------------------------------------------------------------
// frame_protocol_classifier_assert.svh
// Assertion macros shared by the classifier modules; they expect aclk and
// aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef FRAME_PROTOCOL_CLASSIFIER_ASSERT_SVH
`define FRAME_PROTOCOL_CLASSIFIER_ASSERT_SVH

// same-cycle implication
`define FPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/fpc_pkg.sv
// ----------------------------------------------------------------------------
// fpc_pkg
// Types, codes and header offsets of the frame protocol classifier.
// ----------------------------------------------------------------------------
package fpc_pkg;

    localparam int NUM_CLASSES          = 10;
    localparam int COUNTER_BITS_DEFAULT = 48;
    localparam int CNT_OUT_W            = 48;
    localparam int PORT_W               = 16;
    localparam int CFG_INDEX_W          = 2;
    localparam int S_TDATA_W            = 16;
    localparam int M_TDATA_W            = 56;
    localparam int SEL_W                = 4;

    // class counter indexes
    localparam int CLS_ETHER  = 0;
    localparam int CLS_TCP    = 1;
    localparam int CLS_UDP    = 2;
    localparam int CLS_ICMP   = 3;
    localparam int CLS_DNS    = 4;
    localparam int CLS_HTTP   = 5;
    localparam int CLS_IP     = 6;
    localparam int CLS_HTTPS  = 7;
    localparam int CLS_ICMPV6 = 8;
    localparam int CLS_OTHER  = 9;

    // input beat kinds
    localparam logic OP_FRAME_BYTE   = 1'b0;
    localparam logic OP_COUNTER_READ = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WEB_PORT          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECURE_WEB_PORT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NAME_SERVICE_PORT = 2'd2;

    localparam logic [PORT_W-1:0] WEB_PORT_RESET          = 16'd80;
    localparam logic [PORT_W-1:0] SECURE_WEB_PORT_RESET   = 16'd443;
    localparam logic [PORT_W-1:0] NAME_SERVICE_PORT_RESET = 16'd53;

    // result codes
    localparam logic [1:0] NET_NONE = 2'd0;
    localparam logic [1:0] NET_IPV4 = 2'd1;
    localparam logic [1:0] NET_IPV6 = 2'd2;

    localparam logic [2:0] TRN_OTHER  = 3'd0;
    localparam logic [2:0] TRN_TCP    = 3'd1;
    localparam logic [2:0] TRN_UDP    = 3'd2;
    localparam logic [2:0] TRN_ICMP   = 3'd3;
    localparam logic [2:0] TRN_ICMPV6 = 3'd4;

    localparam logic [1:0] SVC_NONE  = 2'd0;
    localparam logic [1:0] SVC_HTTP  = 2'd1;
    localparam logic [1:0] SVC_HTTPS = 2'd2;
    localparam logic [1:0] SVC_DNS   = 2'd3;

    // header values
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP   = 8'd1;
    localparam logic [7:0]  PROTO_TCP    = 8'd6;
    localparam logic [7:0]  PROTO_UDP    = 8'd17;
    localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
    localparam logic [3:0]  IHL_MIN      = 4'd5;

    // byte offsets within the frame
    localparam logic [10:0] POS_MAX        = 11'd2047;
    localparam logic [10:0] POS_ETYPE_HI   = 11'd12;
    localparam logic [10:0] POS_ETYPE_LO   = 11'd13;
    localparam logic [10:0] POS_IHL        = 11'd14;
    localparam logic [10:0] POS_V6_NEXT    = 11'd20;
    localparam logic [10:0] POS_V4_PROTO   = 11'd23;
    localparam logic [6:0]  V4_HDR_BASE    = 7'd14;
    localparam logic [6:0]  V6_PORT_START  = 7'd54;

    typedef struct packed {
        logic [PORT_W-1:0] web_port;
        logic [PORT_W-1:0] secure_web_port;
        logic [PORT_W-1:0] name_service_port;
    } fpc_ports_t;

    typedef struct packed {
        logic [1:0]             network_kind;
        logic [2:0]             transport_kind;
        logic [1:0]             service_kind;
        logic [NUM_CLASSES-1:0] bump;
    } fpc_class_t;

endpackage

### rtl/core/fpc_parser.sv
// ----------------------------------------------------------------------------
// fpc_parser
// Per-frame header capture and classification of the frame on its last byte.
// ----------------------------------------------------------------------------
module fpc_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_en,
    input  logic [7:0]          frame_byte,
    input  logic                end_of_frame,
    input  fpc_pkg::fpc_ports_t ports,
    output fpc_pkg::fpc_class_t cls
);
    import fpc_pkg::*;

    logic [10:0]       pos_reg, pos_next;
    logic [15:0]       frame_type_reg, frame_type_next;
    logic [3:0]        ihl_reg, ihl_next;
    logic [7:0]        proto_reg, proto_next;
    logic [PORT_W-1:0] src_port_reg, src_port_next;
    logic [PORT_W-1:0] dst_port_reg, dst_port_next;

    logic [3:0]  words;
    logic [6:0]  start;
    logic [10:0] start_pos;
    logic        has_ports;
    logic        is_v4, is_v6;
    logic        web_hit, secure_hit, dns_hit;

    // capture of this byte, seen by the classification of the same byte
    always_comb begin
        pos_next        = pos_reg;
        frame_type_next = frame_type_reg;
        ihl_next        = ihl_reg;
        proto_next      = proto_reg;
        src_port_next   = src_port_reg;
        dst_port_next   = dst_port_reg;
        words           = ihl_reg;
        start           = 7'd0;
        has_ports       = 1'b0;
        if (pos_reg != POS_MAX) begin
            if (pos_reg == POS_ETYPE_HI) begin
                frame_type_next[15:8] = frame_byte;
            end else if (pos_reg == POS_ETYPE_LO) begin
                frame_type_next[7:0] = frame_byte;
            end
            if (frame_type_next == ETYPE_IPV4) begin
                // header length taken before this byte's own capture
                words = (ihl_reg < IHL_MIN) ? IHL_MIN : ihl_reg;
                if (pos_reg == POS_IHL) begin
                    ihl_next = frame_byte[3:0];
                end else if (pos_reg == POS_V4_PROTO) begin
                    proto_next = frame_byte;
                end
                start     = V4_HDR_BASE + {1'b0, words, 2'b00};
                has_ports = pos_reg > POS_IHL;
            end else if (frame_type_next == ETYPE_IPV6) begin
                if (pos_reg == POS_V6_NEXT) begin
                    proto_next = frame_byte;
                end
                start     = V6_PORT_START;
                has_ports = 1'b1;
            end
            start_pos = {4'd0, start};
            if (has_ports) begin
                if (pos_reg == start_pos) begin
                    src_port_next[15:8] = frame_byte;
                end else if (pos_reg == start_pos + 11'd1) begin
                    src_port_next[7:0] = frame_byte;
                end else if (pos_reg == start_pos + 11'd2) begin
                    dst_port_next[15:8] = frame_byte;
                end else if (pos_reg == start_pos + 11'd3) begin
                    dst_port_next[7:0] = frame_byte;
                end
            end
            pos_next = pos_reg + 11'd1;
        end else begin
            start_pos = 11'd0;
        end
    end

    assign is_v4      = frame_type_next == ETYPE_IPV4;
    assign is_v6      = frame_type_next == ETYPE_IPV6;
    assign web_hit    = (src_port_next == ports.web_port) ||
                        (dst_port_next == ports.web_port);
    assign secure_hit = (src_port_next == ports.secure_web_port) ||
                        (dst_port_next == ports.secure_web_port);
    assign dns_hit    = (src_port_next == ports.name_service_port) ||
                        (dst_port_next == ports.name_service_port);

    always_comb begin
        cls                 = '0;
        cls.bump[CLS_ETHER] = 1'b1;
        if (is_v4 || is_v6) begin
            cls.network_kind = is_v4 ? NET_IPV4 : NET_IPV6;
            cls.bump[CLS_IP] = 1'b1;
            priority if (proto_next == PROTO_TCP) begin
                cls.transport_kind = TRN_TCP;
                cls.bump[CLS_TCP]  = 1'b1;
                priority if (web_hit) begin
                    cls.service_kind   = SVC_HTTP;
                    cls.bump[CLS_HTTP] = 1'b1;
                end else if (secure_hit) begin
                    cls.service_kind    = SVC_HTTPS;
                    cls.bump[CLS_HTTPS] = 1'b1;
                end else if (dns_hit) begin
                    cls.service_kind  = SVC_DNS;
                    cls.bump[CLS_DNS] = 1'b1;
                end else begin
                    cls.service_kind = SVC_NONE;
                end
            end else if (proto_next == PROTO_UDP) begin
                cls.transport_kind = TRN_UDP;
                cls.bump[CLS_UDP]  = 1'b1;
                if (dns_hit) begin
                    cls.service_kind  = SVC_DNS;
                    cls.bump[CLS_DNS] = 1'b1;
                end
            end else if (is_v4 && proto_next == PROTO_ICMP) begin
                cls.transport_kind = TRN_ICMP;
                cls.bump[CLS_ICMP] = 1'b1;
            end else if (is_v6 && proto_next == PROTO_ICMPV6) begin
                cls.transport_kind   = TRN_ICMPV6;
                cls.bump[CLS_ICMPV6] = 1'b1;
            end else begin
                cls.transport_kind  = TRN_OTHER;
                cls.bump[CLS_OTHER] = 1'b1;
            end
        end else begin
            cls.network_kind    = NET_NONE;
            cls.bump[CLS_OTHER] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            frame_type_reg <= '0;
            ihl_reg        <= '0;
            proto_reg      <= '0;
            src_port_reg   <= '0;
            dst_port_reg   <= '0;
        end else if (byte_en) begin
            if (end_of_frame) begin
                pos_reg        <= '0;
                frame_type_reg <= '0;
                ihl_reg        <= '0;
                proto_reg      <= '0;
                src_port_reg   <= '0;
                dst_port_reg   <= '0;
            end else begin
                pos_reg        <= pos_next;
                frame_type_reg <= frame_type_next;
                ihl_reg        <= ihl_next;
                proto_reg      <= proto_next;
                src_port_reg   <= src_port_next;
                dst_port_reg   <= dst_port_next;
            end
        end
    end

endmodule

### rtl/core/fpc_counters.sv
// ----------------------------------------------------------------------------
// fpc_counters
// Bank of saturating class counters with one read port.
// ----------------------------------------------------------------------------
`include "frame_protocol_classifier_assert.svh"

module fpc_counters #(
    parameter int COUNTER_BITS = fpc_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [fpc_pkg::NUM_CLASSES-1:0] bump_en,
    input  logic [fpc_pkg::SEL_W-1:0]       rd_sel,
    output logic [fpc_pkg::CNT_OUT_W-1:0]   rd_value
);
    import fpc_pkg::*;

    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    logic [COUNTER_BITS-1:0] cnt_reg [NUM_CLASSES];
    logic [63:0]             rd_wide;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                cnt_reg[k] <= '0;
            end
        end else begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (bump_en[k] && cnt_reg[k] != CNT_MAX) begin
                    cnt_reg[k] <= cnt_reg[k] + COUNTER_BITS'(1);
                end
            end
        end
    end

    // reply is the low bits of the counter, zero for a bad selector
    always_comb begin
        rd_wide = 64'd0;
        if (rd_sel < SEL_W'(NUM_CLASSES)) begin
            rd_wide = 64'(cnt_reg[rd_sel]);
        end
        rd_value = rd_wide[CNT_OUT_W-1:0];
    end

    `FPC_ASSERT_NOW(a_ether_covers_ip, 1'b1, cnt_reg[CLS_ETHER] >= cnt_reg[CLS_IP], "ip count above frame count")
    `FPC_ASSERT_NOW(a_ether_covers_other, 1'b1, cnt_reg[CLS_ETHER] >= cnt_reg[CLS_OTHER], "other count above frame count")
    `FPC_ASSERT_NOW(a_ip_covers_tcp, 1'b1, cnt_reg[CLS_IP] >= cnt_reg[CLS_TCP], "tcp count above ip count")

endmodule

### rtl/core/frame_protocol_classifier.sv
// ----------------------------------------------------------------------------
// frame_protocol_classifier
// Byte-wide Ethernet frame classifier with saturating per-class counters.
//
//   channel   dir  carries
//   s_*       in   frame byte or counter read request
//   m_*       out  frame classification or counter read reply
//   cfg_*     in   service port registers, write only
//
// One beat is taken every cycle, except while a result-bearing beat waits in
// the input register for a stalled output. From the input register, header
// capture, classification and counter update go in a single pass to the result register.
// Only a last frame byte or a counter read yields a result beat; other frame
// bytes move on even while m_tready is low. Reset clears the counters and
// the frame state at once, there is no clearing pass.
// ----------------------------------------------------------------------------
`include "frame_protocol_classifier_assert.svh"

module frame_protocol_classifier #(
    parameter int COUNTER_BITS = fpc_pkg::COUNTER_BITS_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpc_pkg::S_TDATA_W-1:0]   s_tdata,   // frame_byte, counter_select
    input  logic                            s_tuser,   // op
    input  logic                            s_tlast,   // end_of_frame
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fpc_pkg::M_TDATA_W-1:0]   m_tdata,   // network_kind, transport_kind,
                                                       // service_kind, counter_value
    output logic                            m_tuser,   // is_read_reply
    input  logic                            cfg_wr_en,
    input  logic [fpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fpc_pkg::PORT_W-1:0]      cfg_wdata
);
    import fpc_pkg::*;

    logic              in_valid_reg;
    logic              in_op_reg;
    logic [7:0]        in_byte_reg;
    logic              in_eof_reg;
    logic [SEL_W-1:0]  in_sel_reg;

    logic              m_valid_reg, m_valid_next;
    logic              m_user_reg;
    logic [1:0]        m_net_reg;
    logic [2:0]        m_trn_reg;
    logic [1:0]        m_svc_reg;
    logic [CNT_OUT_W-1:0] m_cnt_reg;

    fpc_ports_t        ports_reg;
    fpc_class_t        cls;
    logic [NUM_CLASSES-1:0] bump_en;
    logic [CNT_OUT_W-1:0]   rd_value;

    logic needs_out, out_free, advance, load_out, byte_en, s_accept;

    assign needs_out = (in_op_reg == OP_COUNTER_READ) || in_eof_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!needs_out || out_free);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign load_out  = advance && needs_out;
    assign byte_en   = advance && (in_op_reg == OP_FRAME_BYTE);
    assign bump_en   = (byte_en && in_eof_reg) ? cls.bump : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ports_reg.web_port          <= WEB_PORT_RESET;
            ports_reg.secure_web_port   <= SECURE_WEB_PORT_RESET;
            ports_reg.name_service_port <= NAME_SERVICE_PORT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WEB_PORT:          ports_reg.web_port          <= cfg_wdata;
                CFG_SECURE_WEB_PORT:   ports_reg.secure_web_port   <= cfg_wdata;
                CFG_NAME_SERVICE_PORT: ports_reg.name_service_port <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_tuser;
            in_byte_reg <= s_tdata[7:0];
            in_sel_reg  <= s_tdata[11:8];
            in_eof_reg  <= s_tlast;
        end
    end

    fpc_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .byte_en      (byte_en),
        .frame_byte   (in_byte_reg),
        .end_of_frame (in_eof_reg),
        .ports        (ports_reg),
        .cls          (cls)
    );

    fpc_counters #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_counters (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .bump_en  (bump_en),
        .rd_sel   (in_sel_reg),
        .rd_value (rd_value)
    );

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (in_op_reg == OP_COUNTER_READ) begin
                m_user_reg <= 1'b1;
                m_net_reg  <= NET_NONE;
                m_trn_reg  <= TRN_OTHER;
                m_svc_reg  <= SVC_NONE;
                m_cnt_reg  <= rd_value;
            end else begin
                m_user_reg <= 1'b0;
                m_net_reg  <= cls.network_kind;
                m_trn_reg  <= cls.transport_kind;
                m_svc_reg  <= cls.service_kind;
                m_cnt_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = {1'b0, m_cnt_reg, m_svc_reg, m_trn_reg, m_net_reg};

    `FPC_ASSERT_NEXT(a_held_when_blocked, in_valid_reg && needs_out && !out_free, in_valid_reg && $stable(in_eof_reg), "result beat lost while output stalled")
    `FPC_ASSERT_NEXT(a_load_shows_valid, load_out, m_valid_reg, "loaded result not presented")
    `FPC_ASSERT_NOW(a_reply_kinds_zero, m_valid_reg && m_user_reg, m_net_reg == NET_NONE && m_trn_reg == TRN_OTHER && m_svc_reg == SVC_NONE, "read reply carries class codes")

endmodule

### bench/tb_frame_protocol_classifier.sv
// ----------------------------------------------------------------------------
// tb_frame_protocol_classifier
// Self-checking bench for the byte-wide frame classifier. Builds Ethernet
// frames (IPv4 with any header length, IPv6, other EtherTypes, cut-off
// frames) mixed with counter reads, drives them through the stream
// input under several idle/stall patterns and service port settings, and
// compares every result beat against a cycle-free model of the classifier.
// ----------------------------------------------------------------------------
module tb_frame_protocol_classifier;
    import fpc_pkg::*;

    localparam int TALLY_BITS     = COUNTER_BITS_DEFAULT;
    localparam int RANDOM_BEATS   = 1216;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [SEL_W-1:0]       SEL_BAD    = {SEL_W{1'b1}};

    typedef struct packed {
        logic             op;
        logic [7:0]       fbyte;
        logic             eof;
        logic [SEL_W-1:0] sel;
    } beat_t;

    typedef struct packed {
        logic                 reply;
        logic [1:0]           net;
        logic [2:0]           trn;
        logic [1:0]           svc;
        logic [CNT_OUT_W-1:0] count;
    } verdict_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [S_TDATA_W-1:0]      s_tdata   = '0;
    logic                      s_tuser   = 1'b0;
    logic                      s_tlast   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]      m_tdata;
    logic                      m_tuser;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = '0;
    logic [PORT_W-1:0]         cfg_wdata = '0;

    frame_protocol_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    beat_t    pending[$];
    verdict_t verdicts_due[$];
    beat_t    cur_beat;
    verdict_t want;
    int       faults        = 0;
    int       send_idle_pct = 0;
    int       stall_pct     = 0;
    int       quiet_cycles  = 0;

    // service port registers as the block should hold them
    logic [PORT_W-1:0] web_port          = WEB_PORT_RESET;
    logic [PORT_W-1:0] secure_web_port   = SECURE_WEB_PORT_RESET;
    logic [PORT_W-1:0] name_service_port = NAME_SERVICE_PORT_RESET;

    // per-frame header capture and class counters
    logic [10:0]           frame_pos   = '0;
    logic [15:0]           frame_etype = '0;
    logic [3:0]            hdr_words   = '0;
    logic [7:0]            l4_proto    = '0;
    logic [15:0]           src_port    = '0;
    logic [15:0]           dst_port    = '0;
    logic [TALLY_BITS-1:0] tally [NUM_CLASSES] = '{default: '0};

    function automatic bit port_seen(input logic [15:0] port);
        return (src_port == port) || (dst_port == port);
    endfunction

    task automatic bump(input int k);
        if (tally[k] != {TALLY_BITS{1'b1}})
            tally[k] = tally[k] + TALLY_BITS'(1);
    endtask

    task automatic classify_beat(input beat_t bt);
        verdict_t v;
        int       words;
        int       start;
        int       p;
        bit       has_ports;
        bit       v4;
        v = '0;
        if (bt.op == OP_COUNTER_READ) begin
            v.reply = 1'b1;
            if (bt.sel < NUM_CLASSES)
                v.count = CNT_OUT_W'(tally[bt.sel]);
            verdicts_due.insert(verdicts_due.size(), v);
            return;
        end
        if (frame_pos < POS_MAX) begin
            p = int'(frame_pos);
            if (frame_pos == POS_ETYPE_HI) frame_etype[15:8] = bt.fbyte;
            else if (frame_pos == POS_ETYPE_LO) frame_etype[7:0] = bt.fbyte;
            has_ports = 1'b0;
            start = 0;
            if (frame_etype == ETYPE_IPV4) begin
                // header length as it stood before this byte
                words = (hdr_words < IHL_MIN) ? int'(IHL_MIN) : int'(hdr_words);
                if (frame_pos == POS_IHL) hdr_words = bt.fbyte[3:0];
                else if (frame_pos == POS_V4_PROTO) l4_proto = bt.fbyte;
                start = int'(V4_HDR_BASE) + 4 * words;
                has_ports = frame_pos > POS_IHL;
            end else if (frame_etype == ETYPE_IPV6) begin
                if (frame_pos == POS_V6_NEXT) l4_proto = bt.fbyte;
                start = int'(V6_PORT_START);
                has_ports = 1'b1;
            end
            if (has_ports) begin
                if (p == start) src_port[15:8] = bt.fbyte;
                else if (p == start + 1) src_port[7:0] = bt.fbyte;
                else if (p == start + 2) dst_port[15:8] = bt.fbyte;
                else if (p == start + 3) dst_port[7:0] = bt.fbyte;
            end
            frame_pos = frame_pos + 11'd1;
        end
        if (!bt.eof)
            return;

        bump(CLS_ETHER);
        if (frame_etype == ETYPE_IPV4 || frame_etype == ETYPE_IPV6) begin
            v4 = frame_etype == ETYPE_IPV4;
            v.net = v4 ? NET_IPV4 : NET_IPV6;
            bump(CLS_IP);
            if (l4_proto == PROTO_TCP) begin
                v.trn = TRN_TCP;
                bump(CLS_TCP);
                if (port_seen(web_port)) begin
                    v.svc = SVC_HTTP;
                    bump(CLS_HTTP);
                end else if (port_seen(secure_web_port)) begin
                    v.svc = SVC_HTTPS;
                    bump(CLS_HTTPS);
                end else if (port_seen(name_service_port)) begin
                    v.svc = SVC_DNS;
                    bump(CLS_DNS);
                end
            end else if (l4_proto == PROTO_UDP) begin
                v.trn = TRN_UDP;
                bump(CLS_UDP);
                if (port_seen(name_service_port)) begin
                    v.svc = SVC_DNS;
                    bump(CLS_DNS);
                end
            end else if (v4 && l4_proto == PROTO_ICMP) begin
                v.trn = TRN_ICMP;
                bump(CLS_ICMP);
            end else if (!v4 && l4_proto == PROTO_ICMPV6) begin
                v.trn = TRN_ICMPV6;
                bump(CLS_ICMPV6);
            end else begin
                bump(CLS_OTHER);
            end
        end else begin
            bump(CLS_OTHER);
        end
        verdicts_due.insert(verdicts_due.size(), v);
        frame_pos   = '0;
        frame_etype = '0;
        hdr_words   = '0;
        l4_proto    = '0;
        src_port    = '0;
        dst_port    = '0;
    endtask

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------
    task automatic queue_read(input logic [SEL_W-1:0] sel);
        beat_t bt;
        bt.op    = OP_COUNTER_READ;
        bt.fbyte = 8'($urandom_range(255));
        bt.eof   = 1'($urandom_range(1));
        bt.sel   = sel;
        pending.insert(pending.size(), bt);
    endtask

    // len of zero means complete headers plus a short random payload
    task automatic queue_frame(input logic [15:0] etype, input logic [3:0] ihl,
                               input logic [7:0] proto, input logic [15:0] sport,
                               input logic [15:0] dport, input int len);
        beat_t      bt;
        int         start;
        int         total;
        logic [7:0] b;
        bit         is_ip;
        is_ip = (etype == ETYPE_IPV4) || (etype == ETYPE_IPV6);
        if (etype == ETYPE_IPV6)
            start = int'(V6_PORT_START);
        else
            start = int'(V4_HDR_BASE) + 4 * ((ihl < IHL_MIN) ? int'(IHL_MIN) : int'(ihl));
        total = (len > 0) ? len : start + 4 + $urandom_range(16);
        for (int p = 0; p < total; p++) begin
            b = 8'($urandom_range(255));
            if (p == int'(POS_ETYPE_HI)) b = etype[15:8];
            else if (p == int'(POS_ETYPE_LO)) b = etype[7:0];
            else if (etype == ETYPE_IPV4 && p == int'(POS_IHL)) b[3:0] = ihl;
            else if (etype == ETYPE_IPV4 && p == int'(POS_V4_PROTO)) b = proto;
            else if (etype == ETYPE_IPV6 && p == int'(POS_V6_NEXT)) b = proto;
            else if (is_ip && p == start) b = sport[15:8];
            else if (is_ip && p == start + 1) b = sport[7:0];
            else if (is_ip && p == start + 2) b = dport[15:8];
            else if (is_ip && p == start + 3) b = dport[7:0];
            bt.op    = OP_FRAME_BYTE;
            bt.fbyte = b;
            bt.eof   = (p == total - 1);
            bt.sel   = SEL_W'($urandom_range(15));
            pending.insert(pending.size(), bt);
        end
    endtask

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(99);
        if (r < 12) return web_port;
        if (r < 24) return secure_web_port;
        if (r < 36) return name_service_port;
        if (r < 40) return '0;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    task automatic queue_random_traffic(input int budget);
        int          goal;
        int          pick;
        int          r;
        int          len;
        logic [15:0] etype;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        goal = pending.size() + budget;
        while (pending.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                queue_read(SEL_W'($urandom_range(15)));
            end else begin
                r = $urandom_range(99);
                if (r < 45) etype = ETYPE_IPV4;
                else if (r < 85) etype = ETYPE_IPV6;
                else etype = 16'($urandom_range(16'hFFFF));
                ihl = ($urandom_range(99) < 70) ? IHL_MIN : 4'($urandom_range(15));
                case ($urandom_range(5))
                    0: proto = PROTO_ICMP;
                    1, 4: proto = PROTO_TCP;
                    2: proto = PROTO_UDP;
                    3: proto = PROTO_ICMPV6;
                    default: proto = 8'($urandom_range(255));
                endcase
                // a share of frames is cut to a random length of 1 to 60 bytes, often inside the headers
                len = (pick < 37) ? $urandom_range(1, 60) : 0;
                queue_frame(etype, ihl, proto, pick_port(), pick_port(), len);
            end
        end
    endtask

    task automatic write_port_reg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [PORT_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_WEB_PORT:          web_port = val;
            CFG_SECURE_WEB_PORT:   secure_web_port = val;
            CFG_NAME_SERVICE_PORT: name_service_port = val;
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // all beats sent, all results back, then let trailing bytes clear the pipe
    task automatic wait_for_quiet();
        while (pending.size() != 0 || s_tvalid || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // driver
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                classify_beat(cur_beat);
            if (!s_tvalid || s_tready) begin
                if (pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_beat = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, cur_beat.sel, cur_beat.fbyte};
                    s_tuser  <= cur_beat.op;
                    s_tlast  <= cur_beat.eof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [CNT_OUT_W-1:0] got,
                               input logic [CNT_OUT_W-1:0] exp_val);
        if (got !== exp_val) begin
            faults++;
            if (faults <= 10)
                $display("mismatch in %s: expected 0x%0h, got 0x%0h", name, exp_val, got);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    faults++;
                    if (faults <= 10)
                        $display("result beat with nothing expected: user %0b data 0x%0h",
                                 m_tuser, m_tdata);
                end else begin
                    want = verdicts_due.pop_front();
                    check_field("is_read_reply", CNT_OUT_W'(m_tuser), CNT_OUT_W'(want.reply));
                    check_field("network_kind", CNT_OUT_W'(m_tdata[1:0]), CNT_OUT_W'(want.net));
                    check_field("transport_kind", CNT_OUT_W'(m_tdata[4:2]),
                                CNT_OUT_W'(want.trn));
                    check_field("service_kind", CNT_OUT_W'(m_tdata[6:5]), CNT_OUT_W'(want.svc));
                    check_field("counter_value", m_tdata[54:7], want.count);
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty counters, bad selector, short frames, every class
        queue_read(SEL_W'(CLS_ETHER));
        queue_read(SEL_BAD);
        queue_frame(16'h0000, IHL_MIN, PROTO_TCP, 16'd0, 16'd0, 1);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd0, 16'd0, 14);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_TCP, 16'd1234, WEB_PORT_RESET, 0);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_TCP, SECURE_WEB_PORT_RESET, WEB_PORT_RESET, 0);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_TCP, NAME_SERVICE_PORT_RESET,
                    SECURE_WEB_PORT_RESET, 0);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_UDP, 16'd5353, NAME_SERVICE_PORT_RESET, 0);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_UDP, WEB_PORT_RESET, 16'hFFFF, 0);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_ICMP, 16'd0, 16'd0, 0);
        queue_frame(ETYPE_IPV4, IHL_MIN, PROTO_ICMPV6, 16'd0, 16'd0, 0);
        queue_frame(ETYPE_IPV6, IHL_MIN, PROTO_ICMPV6, 16'd0, 16'd0, 0);
        queue_frame(ETYPE_IPV6, IHL_MIN, PROTO_ICMP, 16'd0, 16'd0, 0);
        queue_frame(ETYPE_IPV6, IHL_MIN, PROTO_TCP, NAME_SERVICE_PORT_RESET, 16'd40000, 0);
        // header length below the minimum, and the largest one
        queue_frame(ETYPE_IPV4, 4'd0, PROTO_TCP, 16'd999, SECURE_WEB_PORT_RESET, 0);
        queue_frame(ETYPE_IPV4, 4'hF, PROTO_UDP, NAME_SERVICE_PORT_RESET, 16'd7, 0);
        for (int k = 0; k < NUM_CLASSES; k++)
            queue_read(SEL_W'(k));
        wait_for_quiet();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 82;
                    stall_pct     = 0;
                    write_port_reg(CFG_WEB_PORT, 16'h0000);
                    write_port_reg(CFG_SECURE_WEB_PORT, 16'hFFFF);
                    write_port_reg(CFG_NAME_SERVICE_PORT, 16'($urandom_range(16'hFFFF)));
                    write_port_reg(CFG_UNUSED, 16'($urandom_range(16'hFFFF)));
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 82;
                    write_port_reg(CFG_WEB_PORT, 16'($urandom_range(16'hFFFF)));
                    write_port_reg(CFG_SECURE_WEB_PORT, 16'($urandom_range(16'hFFFF)));
                    write_port_reg(CFG_NAME_SERVICE_PORT, 16'h0000);
                end
                default: begin
                    send_idle_pct = 11;
                    stall_pct     = 11;
                    write_port_reg(CFG_WEB_PORT, 16'hFFFF);
                    write_port_reg(CFG_SECURE_WEB_PORT, 16'h0000);
                    write_port_reg(CFG_NAME_SERVICE_PORT, 16'hFFFF);
                end
            endcase
            queue_random_traffic(RANDOM_BEATS / 8);
            wait_for_quiet();
            queue_random_traffic(RANDOM_BEATS / 8);
            wait_for_quiet();
        end

        if (verdicts_due.size() != 0)
            faults++;
        if (faults == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
